### rtl/export_stream_frame_parser_assert.svh
// Assertion macros for the export stream frame parser checker.
// Expect signals named clk and rst in the scope of use.
`ifndef EXPORT_STREAM_FRAME_PARSER_ASSERT_SVH
`define EXPORT_STREAM_FRAME_PARSER_ASSERT_SVH

// clocked check, switched off while reset is held
`define ESFP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// clocked check that also holds through reset
`define ESFP_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/esfp_pkg.sv
// Shared types and constants of the export stream frame parser.
// No dependencies.
package esfp_pkg;

  localparam int CFG_INDEX_W = 1;

  localparam logic [CFG_INDEX_W-1:0] CFG_HEADER_LIMIT = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_DATA_LIMIT   = 1'd1;

  localparam logic [15:0] HEADER_LIMIT_RESET = 16'd500;
  localparam logic [15:0] DATA_LIMIT_RESET   = 16'd200;

  localparam logic [7:0]  SYNC_BYTE   = 8'h55;
  localparam logic [2:0]  SYNC_RUN_LEN = 3'd4;
  localparam logic [15:0] END_ADDRESS = 16'h5555;
  localparam logic [15:0] WORD_STEP   = 16'd2;

  typedef enum logic [1:0] {
    EV_WRITE = 2'd0,
    EV_START = 2'd1,
    EV_ABORT = 2'd2
  } event_kind_t;

  typedef struct packed {
    event_kind_t kind;
    logic [15:0] addr;
    logic [15:0] data;
  } out_item_t;

  typedef struct packed {
    logic      emit;
    out_item_t item;
  } step_result_t;

endpackage

### rtl/esfp_parser.sv
// Frame parser state machine: holds the parse state and works out the result
// of the byte in the input register. Depends on esfp_pkg.
module esfp_parser (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  logic [7:0]            rx_byte,
  input  logic [15:0]           header_limit,
  input  logic [15:0]           data_limit,
  output esfp_pkg::step_result_t result
);

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_ADDR_L = 3'd1,
    PH_ADDR_H = 3'd2,
    PH_CNT_L  = 3'd3,
    PH_CNT_H  = 3'd4,
    PH_DATA_L = 3'd5,
    PH_DATA_H = 3'd6
  } phase_t;

  phase_t      phase, phase_next;
  logic [15:0] cur_address, cur_address_next;
  logic [15:0] bytes_left, bytes_left_next;
  logic [7:0]  data_low_byte, data_low_byte_next;
  logic [2:0]  sync_run, sync_run_next;

  always_comb begin
    phase_next         = phase;
    cur_address_next   = cur_address;
    bytes_left_next    = bytes_left;
    data_low_byte_next = data_low_byte;
    sync_run_next      = sync_run;
    result.emit        = 1'b0;
    result.item.kind   = esfp_pkg::EV_WRITE;
    result.item.addr   = 16'd0;
    result.item.data   = 16'd0;

    case (phase)
      PH_ADDR_L: begin
        cur_address_next = {8'd0, rx_byte};
        phase_next       = PH_ADDR_H;
      end
      PH_ADDR_H: begin
        cur_address_next = {rx_byte, cur_address[7:0]};
        phase_next = (cur_address_next == esfp_pkg::END_ADDRESS) ? PH_IDLE : PH_CNT_L;
      end
      PH_CNT_L: begin
        bytes_left_next = {8'd0, rx_byte};
        phase_next      = PH_CNT_H;
      end
      PH_CNT_H: begin
        bytes_left_next = {rx_byte, bytes_left[7:0]};
        if (bytes_left_next != 16'd0 && bytes_left_next < header_limit) begin
          phase_next = PH_DATA_L;
        end else begin
          phase_next       = PH_IDLE;
          bytes_left_next  = 16'd0;
          sync_run_next    = 3'd0;
          result.emit      = 1'b1;
          result.item.kind = esfp_pkg::EV_ABORT;
        end
      end
      PH_DATA_L: begin
        if (bytes_left > data_limit) begin
          phase_next       = PH_IDLE;
          bytes_left_next  = 16'd0;
          sync_run_next    = 3'd0;
          result.emit      = 1'b1;
          result.item.kind = esfp_pkg::EV_ABORT;
        end else begin
          data_low_byte_next = rx_byte;
          bytes_left_next    = bytes_left - 16'd1;
          phase_next         = PH_DATA_H;
        end
      end
      PH_DATA_H: begin
        bytes_left_next  = bytes_left - 16'd1;
        result.emit      = 1'b1;
        result.item.kind = esfp_pkg::EV_WRITE;
        result.item.addr = cur_address;
        result.item.data = {rx_byte, data_low_byte};
        cur_address_next = cur_address + esfp_pkg::WORD_STEP;
        phase_next = (bytes_left_next == 16'd0) ? PH_ADDR_L : PH_DATA_L;
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase

    // a byte that lands in idle also counts toward the sync run
    if (phase_next == PH_IDLE) begin
      sync_run_next = (rx_byte == esfp_pkg::SYNC_BYTE) ? sync_run_next + 3'd1 : 3'd0;
      if (sync_run_next == esfp_pkg::SYNC_RUN_LEN) begin
        phase_next       = PH_ADDR_L;
        sync_run_next    = 3'd0;
        result.emit      = 1'b1;
        result.item.kind = esfp_pkg::EV_START;
        result.item.addr = 16'd0;
        result.item.data = 16'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      cur_address   <= 16'd0;
      bytes_left    <= 16'd0;
      data_low_byte <= 8'd0;
      sync_run      <= 3'd0;
    end else if (step) begin
      phase         <= phase_next;
      cur_address   <= cur_address_next;
      bytes_left    <= bytes_left_next;
      data_low_byte <= data_low_byte_next;
      sync_run      <= sync_run_next;
    end
  end

endmodule

### rtl/esfp_out_reg.sv
// Result register of the frame parser with a valid/ready output side.
// Depends on esfp_pkg.
module esfp_out_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  esfp_pkg::out_item_t load_item,
  output logic                free,
  output logic                out_valid,
  input  logic                out_ready,
  output esfp_pkg::out_item_t item
);

  // free: the register can take a new result at this edge
  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item <= load_item;
    end
  end

endmodule

### rtl/export_stream_frame_parser.sv
// Export stream frame parser, top level: input register, limit registers,
// parser and result register. Depends on esfp_pkg, esfp_parser, esfp_out_reg.
//
// Input channel in_valid/in_ready carries one received byte (rx_byte) per
// transaction. The output channel out_valid/out_ready carries at most one
// event per byte: a data write (address and word), a frame start after four
// 0x55 bytes in a row, or an abort on a bad byte count. Bytes that cause no
// event produce no output transaction.
// Path: a taken byte sits in the input register, and the parser step then
// loads its event into the result register, which shows it on out_valid.
// Throughput: one byte per cycle while no event meets a full result register,
// set by the combinational parser step between input and result registers.
// When the receiver stalls, the result register holds its event; the input
// register still takes one more byte, and bytes that cause no event keep
// flowing. Only a byte whose event would land on a full result register waits.
// Limit registers are written through cfg_we/cfg_index/cfg_data; the user
// must do so only while idle, as the block does not enforce it.
// Reset (rst, synchronous) empties both registers, puts the parser in idle
// with a clear sync run, and sets the limits to 500 and 200.
module export_stream_frame_parser (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [esfp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [15:0]                      cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [7:0]                       rx_byte,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [1:0]                       event_kind,
  output logic [15:0]                      write_address,
  output logic [15:0]                      write_data
);

  logic [15:0] header_limit;
  logic [15:0] data_limit;

  logic        held_valid;
  logic [7:0]  held_byte;
  logic        advance;
  logic        free;

  esfp_pkg::step_result_t result;
  esfp_pkg::out_item_t    out_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_limit <= esfp_pkg::HEADER_LIMIT_RESET;
      data_limit   <= esfp_pkg::DATA_LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        esfp_pkg::CFG_HEADER_LIMIT: header_limit <= cfg_data;
        esfp_pkg::CFG_DATA_LIMIT:   data_limit   <= cfg_data;
        default: ;
      endcase
    end
  end

  // the held byte moves on unless its event meets a full result register
  assign advance  = held_valid && (!result.emit || free);
  assign in_ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_byte <= rx_byte;
    end
  end

  esfp_parser u_parser (
    .clk          (clk),
    .rst          (rst),
    .step         (advance),
    .rx_byte      (held_byte),
    .header_limit (header_limit),
    .data_limit   (data_limit),
    .result       (result)
  );

  esfp_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (advance && result.emit),
    .load_item (result.item),
    .free      (free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .item      (out_item)
  );

  assign event_kind    = out_item.kind;
  assign write_address = out_item.addr;
  assign write_data    = out_item.data;

endmodule

### rtl/esfp_checker.sv
// Port-level checks for the export stream frame parser, bound to the top.
// Depends on esfp_pkg and export_stream_frame_parser_assert.svh.
`include "export_stream_frame_parser_assert.svh"

module esfp_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  event_kind,
  input logic [15:0] write_address,
  input logic [15:0] write_data
);

  property p_stall_holds;
    out_valid && !out_ready |=> out_valid && $stable(event_kind)
      && $stable(write_address) && $stable(write_data);
  endproperty

  property p_control_payload_zero;
    out_valid && event_kind != esfp_pkg::EV_WRITE
      |-> write_address == 16'd0 && write_data == 16'd0;
  endproperty

  `ESFP_ASSERT_RST(a_empty_after_reset, $past(rst) |-> !out_valid, "event shown after reset")
  `ESFP_ASSERT(a_stall_holds, p_stall_holds, "stalled event changed")
  `ESFP_ASSERT(a_ready_when_empty, !out_valid |-> in_ready, "input blocked, result reg empty")
  `ESFP_ASSERT(a_control_payload_zero, p_control_payload_zero, "start or abort carries payload")

endmodule

bind export_stream_frame_parser esfp_checker u_esfp_checker (
  .clk           (clk),
  .rst           (rst),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .event_kind    (event_kind),
  .write_address (write_address),
  .write_data    (write_data)
);
